// File: sv/lpf_pkg.sv
// Shared types, codes and defaults for the IPv4 longest-prefix forwarder.
package lpf_pkg;

  localparam int unsigned RoutesDefault = 16;
  localparam int unsigned PortsDefault  = 16;

  // Input command codes.
  localparam logic CMD_ROUTE_WRITE = 1'b0;
  localparam logic CMD_PACKET      = 1'b1;

  // Index of the link-off register in the configuration space.
  localparam logic REG_LINK_OFF = 1'b0;

  typedef enum logic [2:0] {
    V_FORWARD   = 3'd0,
    V_NO_ROUTE  = 3'd1,
    V_LINK_OFF  = 3'd2,
    V_DEFAULT   = 3'd3,
    V_WRITTEN   = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_e;

  // One route table word.
  typedef struct packed {
    logic        valid;
    logic [31:0] network;
    logic [31:0] mask;
    logic [3:0]  port;
  } entry_t;

endpackage

// File: sv/lpf_route_mem.sv
// Route table memory: one write port, one read port with registered read data.
module lpf_route_mem import lpf_pkg::*; #(
  parameter int unsigned Depth = RoutesDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ipv4_longest_prefix_forwarder_top.sv
// Static IPv4 forwarder with a longest-prefix-match route table held in memory.
//
// Requests enter on start/busy: a request is taken at a clock edge with start high
// and busy low. command_i selects a route write or a packet. Each request yields
// exactly one result, shown for one cycle with result_valid_o high; the receiver
// cannot stall it, and the block never holds a result back.
// Route writes and packets without a destination do not raise busy: the result
// appears in the next cycle, so they can be issued every cycle.
// A packet with a destination walks the table one entry per cycle through the
// memory read port in the scan state, then passes the resolve state; busy is high
// through both, so no new request is taken until the lookup has shown its result.
// Only one request is in flight, so a lookup never overlaps a table write.
// After reset the block clears the valid bit of every table entry, one per cycle,
// keeping busy high until the clear is done. Counters reset to zero, link-off to 0.
// The APB port holds the link-off bit at byte address 0; it may be written only
// while the block is idle.
module ipv4_longest_prefix_forwarder_top import lpf_pkg::*; #(
  parameter int unsigned ROUTES = RoutesDefault,
  parameter int unsigned PORTS  = PortsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic        has_destination_i,
  input  logic [31:0] destination_i,
  input  logic [3:0]  route_index_i,
  input  logic [31:0] route_network_i,
  input  logic [31:0] route_mask_i,
  input  logic [3:0]  route_port_i,
  input  logic        route_enable_i,
  // Result channel.
  output logic        result_valid_o,
  output logic [2:0]  verdict_o,
  output logic [3:0]  out_port_o,
  output logic [31:0] forwarded_total_o,
  output logic [31:0] dropped_total_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int unsigned CntW = $clog2(ROUTES + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     dest_q, dest_d;
  logic            hit_q, hit_d;
  logic [31:0]     best_mask_q, best_mask_d;
  logic [3:0]      best_port_q, best_port_d;
  logic            link_off_q, link_off_d;
  logic [31:0]     fwd_cnt_q, fwd_cnt_d;
  logic [31:0]     drop_cnt_q, drop_cnt_d;
  logic            res_valid_q, res_valid_d;
  verdict_e        res_verdict_q, res_verdict_d;
  logic [3:0]      res_port_q, res_port_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  logic entry_hit;
  logic take;
  logic index_ok;
  logic port_ok;
  logic cfg_write;

  lpf_route_mem #(
    .Depth (ROUTES),
    .AddrW (IdxW)
  ) u_route_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // An entry replaces the current best on an equal mask, so the higher index wins.
  assign entry_hit = mem_rdata.valid && ((dest_q & mem_rdata.mask) == mem_rdata.network);
  assign take      = entry_hit && (!hit_q || (mem_rdata.mask >= best_mask_q));
  assign index_ok  = 32'(route_index_i) < 32'(ROUTES);
  assign port_ok   = 32'(best_port_q) < 32'(PORTS);

  assign cfg_write  = psel && penable && pwrite;
  assign link_off_d = (cfg_write && (paddr[2] == REG_LINK_OFF)) ? pwdata[0] : link_off_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    dest_d        = dest_q;
    hit_d         = hit_q;
    best_mask_d   = best_mask_q;
    best_port_d   = best_port_q;
    fwd_cnt_d     = fwd_cnt_q;
    drop_cnt_d    = drop_cnt_q;
    res_valid_d   = 1'b0;
    res_verdict_d = res_verdict_q;
    res_port_d    = res_port_q;
    mem_we        = 1'b0;
    mem_waddr     = cnt_q[IdxW-1:0];
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cnt_q[IdxW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == CntW'(ROUTES - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (command_i == CMD_ROUTE_WRITE) begin
            // Clearing a slot writes an invalid word; its other fields are never read.
            mem_we    = index_ok;
            mem_waddr = IdxW'(route_index_i);
            if (route_enable_i) begin
              mem_wdata = '{valid: 1'b1, network: route_network_i,
                            mask: route_mask_i, port: route_port_i};
            end
            res_valid_d   = 1'b1;
            res_verdict_d = V_WRITTEN;
            res_port_d    = '0;
          end else if (!has_destination_i) begin
            res_valid_d   = 1'b1;
            res_verdict_d = V_DEFAULT;
            res_port_d    = '0;
          end else begin
            dest_d      = destination_i;
            hit_d       = 1'b0;
            best_mask_d = '0;
            best_port_d = '0;
            mem_re      = 1'b1;
            mem_raddr   = '0;
            cnt_d       = CntW'(1);
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // cnt_q is one ahead of the entry whose read data is on hand.
        if (take) begin
          hit_d       = 1'b1;
          best_mask_d = mem_rdata.mask;
          best_port_d = mem_rdata.port;
        end
        if (cnt_q == CntW'(ROUTES)) begin
          cnt_d   = '0;
          state_d = ST_RESOLVE;
        end else begin
          mem_re = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
      ST_RESOLVE: begin
        res_valid_d = 1'b1;
        res_port_d  = '0;
        if (link_off_q) begin
          res_verdict_d = V_LINK_OFF;
          drop_cnt_d    = drop_cnt_q + 32'd1;
        end else if (!hit_q || !port_ok) begin
          res_verdict_d = V_NO_ROUTE;
          drop_cnt_d    = drop_cnt_q + 32'd1;
        end else begin
          res_verdict_d = V_FORWARD;
          res_port_d    = best_port_q;
          fwd_cnt_d     = fwd_cnt_q + 32'd1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      link_off_q  <= 1'b0;
      fwd_cnt_q   <= '0;
      drop_cnt_q  <= '0;
      res_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      link_off_q  <= link_off_d;
      fwd_cnt_q   <= fwd_cnt_d;
      drop_cnt_q  <= drop_cnt_d;
      res_valid_q <= res_valid_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q        <= dest_d;
    best_mask_q   <= best_mask_d;
    best_port_q   <= best_port_d;
    res_verdict_q <= res_verdict_d;
    res_port_q    <= res_port_d;
  end

  assign busy              = (state_q != ST_IDLE);
  assign result_valid_o    = res_valid_q;
  assign verdict_o         = res_verdict_q;
  assign out_port_o        = res_port_q;
  assign forwarded_total_o = fwd_cnt_q;
  assign dropped_total_o   = drop_cnt_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINK_OFF) ? {31'd0, link_off_q} : '0;

endmodule

// File: sv/lpf_checker.sv
// Port-level checks for the IPv4 forwarder, bound to the top level.
module lpf_checker import lpf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       command_i,
  input logic       has_destination_i,
  input logic       result_valid_o,
  input logic [2:0] verdict_o,
  input logic [3:0] out_port_o
);

  // A route write answers in the very next cycle.
  a_write_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_ROUTE_WRITE))
      |=> (result_valid_o && (verdict_o == V_WRITTEN)))
    else $error("route write request did not answer in the next cycle");

  // A packet with a destination starts a table walk.
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_PACKET) && has_destination_i) |=> busy)
    else $error("lookup request did not raise busy");

  // Only a forwarded packet names a port.
  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (verdict_o != V_FORWARD)) |-> (out_port_o == 4'd0))
    else $error("nonzero port on a result that was not forwarded");

  // Results are only shown once the block is idle again.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

endmodule

bind ipv4_longest_prefix_forwarder_top lpf_checker u_lpf_checker (.*);

// File: tb/ipv4_longest_prefix_forwarder_top_tb.sv
// Self-checking testbench for the IPv4 longest-prefix forwarder: directed and random requests.
`timescale 1ns / 1ps

module ipv4_longest_prefix_forwarder_top_tb;
  import lpf_pkg::*;

  // Wait margin in cycles that covers a lookup over the whole table.
  localparam int unsigned LOOKUP_LATENCY = RoutesDefault + 2;
  localparam logic [2:0]  LINK_OFF_ADDR  = {REG_LINK_OFF, 2'b00};

  typedef struct {
    logic        command;
    logic        has_dest;
    logic [31:0] dest;
    logic [3:0]  index;
    logic [31:0] network;
    logic [31:0] mask;
    logic [3:0]  port;
    logic        enable;
  } request_t;

  typedef struct {
    verdict_e    verdict;
    logic [3:0]  port;
    logic [31:0] forwarded;
    logic [31:0] dropped;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic        has_destination_i;
  logic [31:0] destination_i;
  logic [3:0]  route_index_i;
  logic [31:0] route_network_i;
  logic [31:0] route_mask_i;
  logic [3:0]  route_port_i;
  logic        route_enable_i;
  logic        result_valid_o;
  logic [2:0]  verdict_o;
  logic [3:0]  out_port_o;
  logic [31:0] forwarded_total_o;
  logic [31:0] dropped_total_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the route table, counters and link state.
  logic        route_valid [RoutesDefault];
  logic [31:0] route_net   [RoutesDefault];
  logic [31:0] route_mask  [RoutesDefault];
  logic [3:0]  route_port  [RoutesDefault];
  logic [31:0] fwd_count;
  logic [31:0] drop_count;
  logic        link_off_q;

  verdict_t    pending_verdicts[$];
  verdict_t    oldest;
  int unsigned mismatches;
  int unsigned route_writes;
  int unsigned default_sends;
  int unsigned results_seen;

  ipv4_longest_prefix_forwarder_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .has_destination_i (has_destination_i),
    .destination_i     (destination_i),
    .route_index_i     (route_index_i),
    .route_network_i   (route_network_i),
    .route_mask_i      (route_mask_i),
    .route_port_i      (route_port_i),
    .route_enable_i    (route_enable_i),
    .result_valid_o    (result_valid_o),
    .verdict_o         (verdict_o),
    .out_port_o        (out_port_o),
    .forwarded_total_o (forwarded_total_o),
    .dropped_total_o   (dropped_total_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Updates the shadow state for one accepted request and returns its result.
  function automatic verdict_t predict_forwarding(request_t req);
    verdict_t    res;
    logic        hit;
    logic [31:0] best_mask;
    logic [3:0]  best_port;
    res.verdict   = V_WRITTEN;
    res.port      = '0;
    hit           = 1'b0;
    best_mask     = '0;
    best_port     = '0;
    if (req.command == CMD_ROUTE_WRITE) begin
      route_writes++;
      if (int'(req.index) < RoutesDefault) begin
        if (req.enable) begin
          route_net[req.index]  = req.network;
          route_mask[req.index] = req.mask;
          route_port[req.index] = req.port;
        end
        route_valid[req.index] = req.enable;
      end
    end else if (!req.has_dest) begin
      default_sends++;
      res.verdict = V_DEFAULT;
    end else begin
      // The later of two equal masks wins, hence the >= in the scan.
      for (int i = 0; i < RoutesDefault; i++) begin
        if (route_valid[i] && (req.dest & route_mask[i]) == route_net[i] &&
            (!hit || route_mask[i] >= best_mask)) begin
          hit       = 1'b1;
          best_mask = route_mask[i];
          best_port = route_port[i];
        end
      end
      if (hit && int'(best_port) >= PortsDefault) hit = 1'b0;
      if (link_off_q) begin
        res.verdict = V_LINK_OFF;
        drop_count++;
      end else if (!hit) begin
        res.verdict = V_NO_ROUTE;
        drop_count++;
      end else begin
        res.verdict = V_FORWARD;
        res.port    = best_port;
        fwd_count++;
      end
    end
    res.forwarded = fwd_count;
    res.dropped   = drop_count;
    return res;
  endfunction

  // Drives one request and holds it until the block takes it.
  task automatic send_request(request_t req);
    @(negedge clk_i);
    start             = 1'b1;
    command_i         = req.command;
    has_destination_i = req.has_dest;
    destination_i     = req.dest;
    route_index_i     = req.index;
    route_network_i   = req.network;
    route_mask_i      = req.mask;
    route_port_i      = req.port;
    route_enable_i    = req.enable;
    do @(posedge clk_i); while (busy);
    pending_verdicts = {pending_verdicts, predict_forwarding(req)};
  endtask

  function automatic request_t random_fields();
    request_t req;
    req.command  = ($urandom_range(0, 99) < 25) ? CMD_ROUTE_WRITE : CMD_PACKET;
    req.has_dest = ($urandom_range(0, 99) < 92);
    req.dest     = $urandom;
    req.index    = 4'($urandom_range(0, 15));
    req.network  = $urandom;
    req.mask     = $urandom;
    req.port     = 4'($urandom_range(0, 15));
    req.enable   = ($urandom_range(0, 99) < 85);
    return req;
  endfunction

  // Mostly well-formed routes and destinations aimed at the table, with some noise.
  function automatic request_t random_request();
    request_t req;
    int       plen;
    int       pick;
    int       slot;
    req  = random_fields();
    plen = $urandom_range(0, 32);
    pick = $urandom_range(0, 9);
    slot = $urandom_range(0, RoutesDefault - 1);
    if (req.command == CMD_ROUTE_WRITE) begin
      if (pick != 0) req.mask = 32'hFFFF_FFFF << (32 - plen);
      if (pick != 1) req.network = req.network & req.mask;
    end else if (pick < 7) begin
      req.dest = (route_net[slot] & route_mask[slot]) | ($urandom & ~route_mask[slot]);
    end
    return req;
  endfunction

  task automatic write_route(logic [3:0] index, logic [31:0] network, logic [31:0] mask,
                             logic [3:0] port, logic enable);
    request_t req;
    req         = random_fields();
    req.command = CMD_ROUTE_WRITE;
    req.index   = index;
    req.network = network;
    req.mask    = mask;
    req.port    = port;
    req.enable  = enable;
    send_request(req);
  endtask

  task automatic send_packet(logic has_dest, logic [31:0] dest);
    request_t req;
    req          = random_fields();
    req.command  = CMD_PACKET;
    req.has_dest = has_dest;
    req.dest     = dest;
    send_request(req);
  endtask

  task automatic idle_burst();
    repeat ($urandom_range(1, 4)) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  // Lets every pending request finish so the block is idle.
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (LOOKUP_LATENCY) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Writes the link-off bit over APB and reads it back.
  task automatic set_link_off(logic value);
    wait_drained();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = LINK_OFF_ADDR;
    pwdata  = $urandom;
    pwdata[0] = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    link_off_q = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== value) begin
      $error("link_off readback: expected %0d, got %0d", value, prdata[0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_lookup_directed();
    send_packet(1'b1, 32'h0000_0000);                      // empty table
    send_packet(1'b0, 32'hFFFF_FFFF);                      // no destination
    write_route(4'd0, 32'h0000_0000, 32'h0000_0000, 4'd3, 1'b1);
    send_packet(1'b1, 32'hFFFF_FFFF);                      // default route
    write_route(4'd5, 32'h0A00_0000, 32'hFF00_0000, 4'd5, 1'b1);
    write_route(4'd6, 32'h0A01_0000, 32'hFFFF_0000, 4'd6, 1'b1);
    write_route(4'd7, 32'h0A01_0100, 32'hFFFF_FF00, 4'd7, 1'b1);
    write_route(4'd15, 32'hC0A8_0101, 32'hFFFF_FFFF, 4'd15, 1'b1);
    send_packet(1'b1, 32'h0A01_0105);
    send_packet(1'b1, 32'h0A01_FF01);
    send_packet(1'b1, 32'h0A7F_0000);
    send_packet(1'b1, 32'hC0A8_0101);
    send_packet(1'b1, 32'hC0A8_0102);
    // Equal masks: the higher slot must win regardless of write order.
    write_route(4'd9, 32'h0A01_0100, 32'hFFFF_FF00, 4'd9, 1'b1);
    write_route(4'd3, 32'h0A01_0100, 32'hFFFF_FF00, 4'd1, 1'b1);
    send_packet(1'b1, 32'h0A01_0101);
    // A network with bits outside its mask can never match.
    write_route(4'd2, 32'h0B00_00FF, 32'hFF00_0000, 4'd2, 1'b1);
    send_packet(1'b1, 32'h0B00_00FF);
    write_route(4'd4, 32'h00F0_00F0, 32'hF0F0_F0F0, 4'd4, 1'b1);
    send_packet(1'b1, 32'h0AF0_0AF5);
    write_route(4'd0, 32'h0000_0000, 32'h0000_0000, 4'd3, 1'b0);
    send_packet(1'b1, 32'h0102_0304);
    write_route(4'd9, 32'h0A01_0100, 32'hFFFF_FF00, 4'd9, 1'b0);
    send_packet(1'b1, 32'h0A01_0101);
    write_route(4'd1, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b1);
    send_packet(1'b1, 32'h0102_0304);
  endtask

  task automatic test_link_off();
    set_link_off(1'b1);
    send_packet(1'b1, 32'h0A01_0101);
    send_packet(1'b0, 32'h0A01_0101);
    write_route(4'd1, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b0);
    send_packet(1'b1, 32'h0102_0304);
    set_link_off(1'b0);
    send_packet(1'b1, 32'h0102_0304);
  endtask

  task automatic test_random_traffic(int unsigned count, bit with_idle);
    repeat (count) begin
      send_request(random_request());
      if (with_idle && $urandom_range(0, 3) == 0) idle_burst();
    end
  endtask

  task automatic test_drain_pause();
    test_random_traffic(20, 1'b0);
    wait_drained();
    test_random_traffic(20, 1'b1);
  endtask

  // Every accepted result is checked against the oldest pending request.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("result with no request pending: verdict %0d", verdict_o);
        mismatches++;
      end else begin
        oldest = pending_verdicts.pop_front();
        if (verdict_o !== oldest.verdict) begin
          $error("verdict: expected %0d, got %0d", oldest.verdict, verdict_o);
          mismatches++;
        end
        if (out_port_o !== oldest.port) begin
          $error("out_port: expected %0d, got %0d", oldest.port, out_port_o);
          mismatches++;
        end
        if (forwarded_total_o !== oldest.forwarded) begin
          $error("forwarded_total: expected %0d, got %0d", oldest.forwarded,
                 forwarded_total_o);
          mismatches++;
        end
        if (dropped_total_o !== oldest.dropped) begin
          $error("dropped_total: expected %0d, got %0d", oldest.dropped, dropped_total_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned guard;
    rst_ni            = 1'b0;
    start             = 1'b0;
    command_i         = CMD_ROUTE_WRITE;
    has_destination_i = 1'b0;
    destination_i     = '0;
    route_index_i     = '0;
    route_network_i   = '0;
    route_mask_i      = '0;
    route_port_i      = '0;
    route_enable_i    = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    fwd_count         = '0;
    drop_count        = '0;
    link_off_q        = 1'b0;
    mismatches        = 0;
    route_writes      = 0;
    default_sends     = 0;
    results_seen      = 0;
    for (int i = 0; i < RoutesDefault; i++) begin
      route_valid[i] = 1'b0;
      route_net[i]   = '0;
      route_mask[i]  = '0;
      route_port[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_lookup_directed();
    test_link_off();
    test_random_traffic(700, 1'b1);
    set_link_off(1'b1);
    test_random_traffic(150, 1'b1);
    set_link_off(1'b0);
    test_drain_pause();
    test_random_traffic(550, 1'b1);
    // The last stretch runs back to back.
    test_random_traffic(450, 1'b0);

    @(negedge clk_i);
    start = 1'b0;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 100 * LOOKUP_LATENCY) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LOOKUP_LATENCY + 4) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d requests never produced a result", pending_verdicts.size());
      mismatches++;
    end
    $display("Checked %0d results: %0d route writes, %0d without destination,",
             results_seen, route_writes, default_sends);
    $display("%0d forwarded, %0d dropped; link up and down, idle gaps and back-to-back runs.",
             fwd_count, drop_count);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/lpf_pkg.sv
sv/lpf_route_mem.sv
sv/ipv4_longest_prefix_forwarder_top.sv
sv/lpf_checker.sv
tb/ipv4_longest_prefix_forwarder_top_tb.sv
